FILE: hdl/lfu_pkg.sv
// Shared types and constants for the LFU cache.
package lfu_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int OCC_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 5;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 31;
  localparam int CNT_W   = 32;

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_TOUCH,
    CMD_INSERT
  } cmd_op_t;

  typedef struct packed {
    logic                    kind;
    logic signed [KEY_W-1:0] key;
    logic [VAL_W-1:0]        value;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
  } rsp_t;

  // Scan word handed from cell to cell.
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] hit_rank;
    logic [VAL_W-1:0] hit_value;
    logic             have_vic;
    logic [IDX_W-1:0] vic_idx;
    logic [CNT_W-1:0] vic_count;
    logic [IDX_W-1:0] vic_rank;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
  } scan_t;

  // Update broadcast to every cell.
  typedef struct packed {
    cmd_op_t          op;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] old_rank;
    logic             wr_value;
    logic             evict;
    logic [IDX_W-1:0] vic_idx;
    logic [IDX_W-1:0] vic_rank;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } cmd_t;

endpackage

FILE: hdl/lfu_cell.sv
// One cache entry: scan stage plus update logic.
module lfu_cell import lfu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] cell_id,
  input  scan_t            tok_in,
  output scan_t            tok_out,
  input  logic             cmd_valid,
  input  cmd_t             cmd
);

  logic             valid;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] rank;

  scan_t tok_next;
  logic  is_vic;

  always_comb begin
    tok_next = tok_in;
    if (valid && key == tok_in.key && !tok_in.hit) begin
      tok_next.hit       = 1'b1;
      tok_next.hit_idx   = cell_id;
      tok_next.hit_rank  = rank;
      tok_next.hit_value = value;
    end
    if (valid) begin
      if (!tok_in.have_vic || count < tok_in.vic_count ||
          (count == tok_in.vic_count && rank > tok_in.vic_rank)) begin
        tok_next.have_vic  = 1'b1;
        tok_next.vic_idx   = cell_id;
        tok_next.vic_count = count;
        tok_next.vic_rank  = rank;
      end
    end else if (!tok_in.free_found) begin
      tok_next.free_found = 1'b1;
      tok_next.free_idx   = cell_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

  assign is_vic = cmd.evict && cmd.vic_idx == cell_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd_valid) begin
      case (cmd.op)
        CMD_TOUCH: begin
          if (cmd.slot == cell_id) begin
            rank <= '0;
            if (count != '1) count <= count + 1'b1;
            if (cmd.wr_value) value <= cmd.value;
          end else if (valid && rank < cmd.old_rank) begin
            rank <= rank + 1'b1;
          end
        end
        CMD_INSERT: begin
          if (cmd.slot == cell_id) begin
            valid <= 1'b1;
            key   <= cmd.key;
            value <= cmd.value;
            count <= CNT_W'(1);
            rank  <= '0;
          end else if (is_vic) begin
            valid <= 1'b0;
          end else if (valid) begin
            // drop the gap left by the victim, then age for the newcomer
            rank <= rank - IDX_W'(cmd.evict && rank > cmd.vic_rank) + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/lfu_cache.sv
// LFU cache top level: request control and the row of entry cells.
//
//   channel | signals                        | moves
//   in      | in_valid, in_stall, in_item    | request word (req_t)
//   out     | out_valid, out_stall, out_item | result word (rsp_t)
//   cfg     | cfg_valid, cfg_ready, cfg_data | capacity_in_use
//
// A request's scan word is registered in tok0, then in each of the 16 cells in order;
// then the decision stage registers result and update, which the cells then apply.
// One request is in flight at a time; in_stall is high until the update is issued.
// A waiting result holds the decision stage while out_stall is high.
// Reset empties the cache and sets capacity to 16.
module lfu_cache import lfu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  req_t             in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output rsp_t             out_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t           state;
  req_t             req;
  logic [CAP_W-1:0] capacity;
  logic [OCC_W-1:0] occupancy;
  scan_t            tok0;
  scan_t            chain [ENTRIES+1];
  scan_t            done_tok;
  cmd_t             cmd;
  logic             cmd_valid;

  logic [OCC_W-1:0] cap_eff;
  rsp_t             rsp_next;
  cmd_t             cmd_next;
  logic [OCC_W-1:0] occ_next;
  logic             evict;
  logic             start_req;
  logic             finish_go;
  scan_t            tok0_next;

  assign in_stall  = state != ST_IDLE;
  assign cfg_ready = 1'b1;
  assign chain[0]  = tok0;
  assign start_req = state == ST_IDLE && in_valid;
  assign finish_go = state == ST_FINISH && (!out_valid || !out_stall);

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lfu_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_id  (IDX_W'(i)),
      .tok_in   (chain[i]),
      .tok_out  (chain[i+1]),
      .cmd_valid(cmd_valid),
      .cmd      (cmd)
    );
  end

  always_comb begin
    tok0_next       = '0;
    tok0_next.valid = start_req;
    tok0_next.key   = in_item.key;
  end

  always_comb begin
    if (OCC_W'(capacity) > OCC_W'(ENTRIES)) cap_eff = OCC_W'(ENTRIES);
    else cap_eff = OCC_W'(capacity);
  end

  always_comb begin
    rsp_next          = '0;
    cmd_next          = '0;
    cmd_next.op       = CMD_NONE;
    cmd_next.key      = done_tok.key;
    cmd_next.value    = req.value;
    cmd_next.vic_idx  = done_tok.vic_idx;
    cmd_next.vic_rank = done_tok.vic_rank;
    occ_next          = occupancy;
    evict             = 1'b0;
    if (cap_eff != '0) begin
      if (done_tok.hit) begin
        rsp_next.found = 1'b1;
        if (req.kind == KIND_GET) rsp_next.read_value = done_tok.hit_value;
        cmd_next.op       = CMD_TOUCH;
        cmd_next.slot     = done_tok.hit_idx;
        cmd_next.old_rank = done_tok.hit_rank;
        cmd_next.wr_value = req.kind == KIND_PUT;
      end else if (req.kind == KIND_PUT) begin
        evict = occupancy >= cap_eff && done_tok.have_vic;
        cmd_next.evict   = evict;
        rsp_next.evicted = evict;
        if (evict) begin
          cmd_next.op = CMD_INSERT;
          if (done_tok.free_found && done_tok.free_idx < done_tok.vic_idx)
            cmd_next.slot = done_tok.free_idx;
          else
            cmd_next.slot = done_tok.vic_idx;
        end else if (done_tok.free_found) begin
          cmd_next.op   = CMD_INSERT;
          cmd_next.slot = done_tok.free_idx;
          occ_next      = occupancy + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      capacity   <= CAP_W'(16);
      occupancy  <= '0;
      out_valid  <= 1'b0;
      cmd_valid  <= 1'b0;
      tok0.valid <= 1'b0;
    end else begin
      cmd_valid <= finish_go;
      tok0      <= tok0_next;
      out_valid <= finish_go || (out_valid && out_stall);
      if (cfg_valid && cfg_ready) capacity <= cfg_data;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req   <= in_item;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (chain[ENTRIES].valid) begin
            done_tok <= chain[ENTRIES];
            state    <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // hold until the result register is free
          if (finish_go) begin
            out_item  <= rsp_next;
            cmd       <= cmd_next;
            occupancy <= occ_next;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
